// ----- rtl/tfdt_pkg.sv -----
// shared types, constants and helpers of the fragment depth test
`default_nettype none
package tfdt_pkg;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;

	localparam int CFG_IDX_W = 1;
	localparam int DIM_W     = 9;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS  = 1'b1;
	localparam logic [DIM_W-1:0]     DIM_RESET        = 9'd128;

	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_TEST  = 1'b1;

	localparam logic [15:0] DEPTH_FAR = 16'h8000;
	localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

	// datapath widths
	localparam int NDC_Q_W  = 23;
	localparam int NDC_W    = 25;
	localparam int EDGE_W   = 41;
	localparam int MAG_W    = 40;
	localparam int MAG_LO_W = 24;
	localparam int AREA_W   = 34;
	localparam int ACC_W    = 60;
	localparam int NUM_W    = 59;
	localparam int DEN_W    = 34;
	localparam int REM_W    = 35;
	localparam int MA_W     = 26;
	localparam int MB_W     = 18;
	localparam int PROD_W   = 44;
	localparam int CNT_W    = 6;
	localparam int STEP_W   = 4;

	localparam logic [STEP_W-1:0] STEP_AREA_END = 4'd1;
	localparam logic [STEP_W-1:0] STEP_EAB_END  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_EBC_END  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_EDGE_END = 4'd7;
	localparam logic [STEP_W-1:0] STEP_Z_FIRST  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_Z_END    = 4'd13;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_DIVX,
		ST_DIVY,
		ST_MUL,
		ST_CHECK,
		ST_ZDIV,
		ST_ZEND,
		ST_FIN
	} state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = 9'd1;
		end else if (d > 9'd256) begin
			r = 9'd256;
		end else begin
			r = d;
		end
		return r;
	endfunction

	function automatic logic top_left(input logic signed [16:0] dx, input logic signed [16:0] dy);
		return (dy > 17'sd0) || ((dy == 17'sd0) && (dx < 17'sd0));
	endfunction

	function automatic logic edge_accepts(input logic signed [EDGE_W-1:0] e, input logic tl);
		return (e < 0) || ((e == '0) && tl);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tfdt_if.sv -----
// request, result and register write channels
`default_nettype none
interface tfdt_frag_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [7:0]         pixel_x;
	logic [7:0]         pixel_y;
	logic signed [15:0] ax;
	logic signed [15:0] ay;
	logic [15:0]        az;
	logic signed [15:0] bx;
	logic signed [15:0] by_coord;
	logic [15:0]        bz;
	logic signed [15:0] cx;
	logic signed [15:0] cy;
	logic [15:0]        cz;
	modport source(output valid, cmd, pixel_x, pixel_y, ax, ay, az, bx, by_coord, bz,
		cx, cy, cz, input ready);
	modport sink(input valid, cmd, pixel_x, pixel_y, ax, ay, az, bx, by_coord, bz,
		cx, cy, cz, output ready);
endinterface

interface tfdt_res_if;
	logic        valid;
	logic        ready;
	logic        covered;
	logic        depth_written;
	logic [15:0] depth_value;
	modport source(output valid, covered, depth_written, depth_value, input ready);
	modport sink(input valid, covered, depth_written, depth_value, output ready);
endinterface

interface tfdt_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [8:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/triangle_fragment_depth_test.sv -----
// top level: triangle coverage and z-buffer depth test over a shared multiplier and divider
// One request at a time. A clear goes from the idle state through a start state to its
// result. A test first runs the pixel center through a bit-serial divider, for x and then
// for y. It then forms the edge and area products on one 26x18 multiplier, and a coverage
// check follows. A covered fragment adds 6 more products for the depth sum and a divide by
// the triangle area. The result then waits until it is taken. The depth store is a
// MAX_COLUMNS x MAX_ROWS memory with no reset; an entry must be cleared before it is
// tested. Register writes are taken in any cycle and belong between requests.
`default_nettype none
module triangle_fragment_depth_test #(
	parameter int MAX_COLUMNS = tfdt_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tfdt_pkg::MAX_ROWS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tfdt_cfg_if.sink    cfg,
	tfdt_frag_if.sink   frag,
	tfdt_res_if.source  res
);
	import tfdt_pkg::*;

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_n;

	logic [DIM_W-1:0] width_q, rows_q;

	logic               cmd_q;
	logic [7:0]         pix_x_q, pix_y_q;
	logic signed [15:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [15:0]        az_q, bz_q, cz_q;
	logic [AW-1:0]      addr_q;

	logic signed [NDC_W-1:0]  px_q, py_q;
	logic signed [AREA_W-1:0] area_q;
	logic signed [EDGE_W-1:0] eab_q, ebc_q, eca_q;
	logic signed [ACC_W-1:0]  acc_q, acc_n;
	logic signed [PROD_W-1:0] prod_q;
	logic [STEP_W-1:0]        step_q;
	logic                     phase_q;

	logic [NUM_W-1:0] quo_q, quo_n;
	logic [REM_W-1:0] rem_q, rem_n, div_t;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             div_ge;

	logic        res_cov_q, res_wr_q;
	logic [15:0] res_val_q;
	logic        out_valid_q, out_cov_q, out_wr_q;
	logic [15:0] out_val_q;

	logic [15:0] rd_q;
	logic [15:0] depth_mem [DEPTH];

	// control outputs
	logic        in_ready, mem_we, out_load;
	logic [15:0] mem_wd;

	// address of the request
	int col_i, row_i;
	always_comb begin
		col_i = 0;
		row_i = 0;
		for (int i = 0; i < 256; i++) begin
			if (frag.pixel_x == i[7:0]) col_i = i % MAX_COLUMNS;
			if (frag.pixel_y == i[7:0]) row_i = i % MAX_ROWS;
		end
	end

	// vertex differences
	logic signed [16:0] d_bax, d_bay, d_cax, d_cay, d_cbx, d_cby, d_acx, d_acy;
	assign d_bax = 17'(bx_q) - 17'(ax_q);
	assign d_bay = 17'(by_q) - 17'(ay_q);
	assign d_cax = 17'(cx_q) - 17'(ax_q);
	assign d_cay = 17'(cy_q) - 17'(ay_q);
	assign d_cbx = 17'(cx_q) - 17'(bx_q);
	assign d_cby = 17'(cy_q) - 17'(by_q);
	assign d_acx = 17'(ax_q) - 17'(cx_q);
	assign d_acy = 17'(ay_q) - 17'(cy_q);

	// multiplier operand selection
	logic signed [15:0]       u_sel;
	logic signed [MA_W-1:0]   p_diff, op_a;
	logic signed [MB_W-1:0]   op_b;
	logic signed [EDGE_W-1:0] e_sel;
	logic [MAG_W-1:0]         e_mag;
	logic [15:0]              z_sel;
	logic signed [PROD_W-1:0] mult;

	always_comb begin
		case (step_q)
			4'd2, 4'd3: u_sel = step_q[0] ? ax_q : ay_q;
			4'd4, 4'd5: u_sel = step_q[0] ? bx_q : by_q;
			default:    u_sel = step_q[0] ? cx_q : cy_q;
		endcase
		p_diff = (step_q[0] ? MA_W'(px_q) : MA_W'(py_q)) - MA_W'(u_sel);

		case (step_q)
			4'd8, 4'd9:   begin e_sel = ebc_q; z_sel = az_q; end
			4'd10, 4'd11: begin e_sel = eca_q; z_sel = bz_q; end
			default:      begin e_sel = eab_q; z_sel = cz_q; end
		endcase
		e_mag = e_sel[EDGE_W-1] ? MAG_W'(-e_sel) : MAG_W'(e_sel);

		case (step_q)
			4'd0:    begin op_a = MA_W'(d_cay); op_b = MB_W'(d_bax); end
			4'd1:    begin op_a = MA_W'(d_cax); op_b = MB_W'(d_bay); end
			4'd2:    begin op_a = p_diff; op_b = MB_W'(d_bax); end
			4'd3:    begin op_a = p_diff; op_b = MB_W'(d_bay); end
			4'd4:    begin op_a = p_diff; op_b = MB_W'(d_cbx); end
			4'd5:    begin op_a = p_diff; op_b = MB_W'(d_cby); end
			4'd6:    begin op_a = p_diff; op_b = MB_W'(d_acx); end
			4'd7:    begin op_a = p_diff; op_b = MB_W'(d_acy); end
			4'd8, 4'd10, 4'd12: begin
				op_a = signed'(MA_W'(e_mag[MAG_LO_W-1:0]));
				op_b = signed'(MB_W'(z_sel));
			end
			default: begin
				op_a = signed'(MA_W'(e_mag[MAG_W-1:MAG_LO_W]));
				op_b = signed'(MB_W'(z_sel));
			end
		endcase
		mult = PROD_W'(op_a) * PROD_W'(op_b);
	end

	// accumulate
	logic [AREA_W-1:0] area_mag;
	assign area_mag = area_q[AREA_W-1] ? AREA_W'(-area_q) : AREA_W'(area_q);

	always_comb begin
		case (step_q)
			4'd0, 4'd2, 4'd4, 4'd6: acc_n = ACC_W'(prod_q);
			4'd1, 4'd3, 4'd5, 4'd7: acc_n = acc_q - ACC_W'(prod_q);
			4'd8:                   acc_n = ACC_W'(prod_q) + ACC_W'(area_mag >> 1);
			4'd10, 4'd12:           acc_n = acc_q + ACC_W'(prod_q);
			default:                acc_n = acc_q + (ACC_W'(prod_q) <<< MAG_LO_W);
		endcase
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		div_t  = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};
		div_ge = div_t >= {1'b0, den_q};
		rem_n  = div_ge ? (div_t - {1'b0, den_q}) : div_t;
		quo_n  = {quo_q[NUM_W-2:0], div_ge};
	end

	// coverage
	logic covered_now;
	assign covered_now = edge_accepts(eab_q, top_left(d_bax, d_bay))
		&& edge_accepts(ebc_q, top_left(d_cbx, d_cby))
		&& edge_accepts(eca_q, top_left(d_acx, d_acy));

	logic [15:0] z_clamped;
	assign z_clamped = (quo_q > NUM_W'(DEPTH_MAX)) ? DEPTH_MAX : quo_q[15:0];

	logic [NDC_Q_W-1:0] num_x, num_y;
	assign num_x = {pix_x_q, 1'b1, 14'b0};
	assign num_y = {pix_y_q, 1'b1, 14'b0};

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (frag.valid) state_n = ST_START;
			ST_START: state_n = (cmd_q == CMD_CLEAR) ? ST_FIN : ST_DIVX;
			ST_DIVX:  if (cnt_q == CNT_W'(1)) state_n = ST_DIVY;
			ST_DIVY:  if (cnt_q == CNT_W'(1)) state_n = ST_MUL;
			ST_MUL: begin
				if (phase_q && step_q == STEP_EDGE_END) state_n = ST_CHECK;
				else if (phase_q && step_q == STEP_Z_END) state_n = ST_ZDIV;
			end
			ST_CHECK: state_n = (area_q == '0 || !covered_now) ? ST_FIN : ST_MUL;
			ST_ZDIV:  if (cnt_q == CNT_W'(1)) state_n = ST_ZEND;
			ST_ZEND:  state_n = ST_FIN;
			ST_FIN:   if (out_load) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		mem_wd   = DEPTH_FAR;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_START: mem_we = (cmd_q == CMD_CLEAR);
			ST_ZEND: begin
				mem_we = z_clamped < rd_q;
				mem_wd = z_clamped;
			end
			ST_FIN:   out_load = !out_valid_q || res.ready;
			default:  ;
		endcase
	end

	assign frag.ready = in_ready;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= DIM_RESET;
			rows_q      <= DIM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg.valid) begin
				case (cfg.index)
					REG_SCREEN_WIDTH: width_q <= cfg.data;
					REG_SCREEN_ROWS:  rows_q <= cfg.data;
					default:          ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_ready && frag.valid) begin
			cmd_q   <= frag.cmd;
			pix_x_q <= frag.pixel_x;
			pix_y_q <= frag.pixel_y;
			ax_q    <= frag.ax;
			ay_q    <= frag.ay;
			az_q    <= frag.az;
			bx_q    <= frag.bx;
			by_q    <= frag.by_coord;
			bz_q    <= frag.bz;
			cx_q    <= frag.cx;
			cy_q    <= frag.cy;
			cz_q    <= frag.cz;
			addr_q  <= AW'(row_i * MAX_COLUMNS + col_i);
		end
		case (state_q)
			ST_START: begin
				res_cov_q <= 1'b0;
				res_wr_q  <= 1'b1;
				res_val_q <= DEPTH_FAR;
				quo_q     <= {num_x, {(NUM_W-NDC_Q_W){1'b0}}};
				rem_q     <= '0;
				den_q     <= DEN_W'(clamp_dim(width_q));
				cnt_q     <= CNT_W'(NDC_Q_W);
			end
			ST_DIVX: begin
				if (cnt_q == CNT_W'(1)) begin
					px_q  <= signed'(NDC_W'(quo_n[NDC_Q_W-1:0])) - NDC_W'(16384);
					quo_q <= {num_y, {(NUM_W-NDC_Q_W){1'b0}}};
					rem_q <= '0;
					den_q <= DEN_W'(clamp_dim(rows_q));
					cnt_q <= CNT_W'(NDC_Q_W);
				end else begin
					quo_q <= quo_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_DIVY: begin
				quo_q <= quo_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					py_q    <= signed'(NDC_W'(quo_n[NDC_Q_W-1:0])) - NDC_W'(16384);
					step_q  <= '0;
					phase_q <= 1'b0;
				end
			end
			ST_MUL: begin
				phase_q <= !phase_q;
				if (!phase_q) begin
					prod_q <= mult;
				end else begin
					acc_q  <= acc_n;
					step_q <= step_q + STEP_W'(1);
					case (step_q)
						STEP_AREA_END: area_q <= AREA_W'(acc_n);
						STEP_EAB_END:  eab_q <= EDGE_W'(acc_n);
						STEP_EBC_END:  ebc_q <= EDGE_W'(acc_n);
						STEP_EDGE_END: eca_q <= EDGE_W'(acc_n);
						default:       ;
					endcase
					if (step_q == STEP_Z_END) begin
						quo_q <= NUM_W'(acc_n);
						rem_q <= '0;
						den_q <= DEN_W'(area_mag);
						cnt_q <= CNT_W'(NUM_W);
					end
				end
			end
			ST_CHECK: begin
				res_cov_q <= 1'b0;
				res_wr_q  <= 1'b0;
				res_val_q <= '0;
				step_q    <= STEP_Z_FIRST;
				phase_q   <= 1'b0;
			end
			ST_ZDIV: begin
				quo_q <= quo_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_ZEND: begin
				res_cov_q <= 1'b1;
				res_wr_q  <= mem_we;
				res_val_q <= z_clamped;
			end
			default: ;
		endcase
		if (out_load) begin
			out_cov_q <= res_cov_q;
			out_wr_q  <= res_wr_q;
			out_val_q <= res_val_q;
		end
	end

	// depth store
	always_ff @(posedge clk) begin
		if (mem_we) depth_mem[addr_q] <= mem_wd;
		rd_q <= depth_mem[addr_q];
	end

	assign res.valid         = out_valid_q;
	assign res.covered       = out_cov_q;
	assign res.depth_written = out_wr_q;
	assign res.depth_value   = out_val_q;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the triangle fragment depth test: directed table, then random requests
`default_nettype none
module testbench;
	import tfdt_pkg::*;

	logic clk;
	logic arst_n;

	tfdt_cfg_if  cfg();
	tfdt_frag_if frag();
	tfdt_res_if  res();

	triangle_fragment_depth_test i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.frag(frag),
		.res(res)
	);

	typedef struct {
		logic               cmd;
		logic [7:0]         px;
		logic [7:0]         py;
		logic signed [15:0] ax, ay;
		logic [15:0]        az;
		logic signed [15:0] bx, by;
		logic [15:0]        bz;
		logic signed [15:0] cx, cy;
		logic [15:0]        cz;
	} frag_req_t;

	typedef struct {
		logic        covered;
		logic        written;
		logic [15:0] depth;
	} frag_res_t;

	// directed row: request plus an optional typed-in result
	typedef struct {
		frag_req_t req;
		logic      typed;
		frag_res_t res;
	} dir_row_t;

	logic [15:0] zbuf [0:65535];
	logic [8:0]  width_reg;
	logic [8:0]  rows_reg;

	frag_res_t expected_q[$];
	int        errors;
	int        n_results;
	int        n_covered;
	int        n_written;
	int        n_cleared;
	bit        done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("timeout at %0t", $time);
		$display("Verification failed");
		$finish;
	end

	function automatic longint dim_clamp(logic [8:0] d);
		if (d == 0) return 1;
		if (d > 256) return 256;
		return longint'(d);
	endfunction

	function automatic longint center_ndc(logic [7:0] p, logic [8:0] d);
		longint num;
		num = ((2 * longint'(p)) + 1) << 14;
		return num / dim_clamp(d) - 16384;
	endfunction

	function automatic longint edge_fn(longint ux, longint uy, longint vx, longint vy,
		longint qx, longint qy);
		return (vx - ux) * (qy - uy) - (qx - ux) * (vy - uy);
	endfunction

	function automatic bit is_top_left(longint ux, longint uy, longint vx, longint vy);
		return (vy - uy > 0) || ((vy == uy) && (vx - ux < 0));
	endfunction

	function automatic bit passes(longint e, bit tl);
		return (e < 0) || ((e == 0) && tl);
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	// depth test predictor: updates the z-buffer copy and returns the result
	function automatic frag_res_t depth_test(frag_req_t r);
		frag_res_t o;
		int        idx;
		longint    qx, qy, area, eab, ebc, eca, ar;
		logic [127:0] num;
		logic [127:0] z;
		idx = int'({r.py, r.px});
		o = '{1'b0, 1'b0, 16'd0};
		if (r.cmd == CMD_CLEAR) begin
			zbuf[idx] = DEPTH_FAR;
			o.written = 1'b1;
			o.depth = DEPTH_FAR;
			return o;
		end
		qx = center_ndc(r.px, width_reg);
		qy = center_ndc(r.py, rows_reg);
		area = edge_fn(r.ax, r.ay, r.bx, r.by, r.cx, r.cy);
		if (area == 0) return o;
		eab = edge_fn(r.ax, r.ay, r.bx, r.by, qx, qy);
		ebc = edge_fn(r.bx, r.by, r.cx, r.cy, qx, qy);
		eca = edge_fn(r.cx, r.cy, r.ax, r.ay, qx, qy);
		if (!(passes(eab, is_top_left(r.ax, r.ay, r.bx, r.by)) &&
			passes(ebc, is_top_left(r.bx, r.by, r.cx, r.cy)) &&
			passes(eca, is_top_left(r.cx, r.cy, r.ax, r.ay)))) return o;
		ar = absl(area);
		num = 128'(absl(ebc)) * r.az + 128'(absl(eca)) * r.bz + 128'(absl(eab)) * r.cz;
		z = (num + 128'(ar / 2)) / 128'(ar);
		if (z > 128'hFFFF) z = 128'hFFFF;
		o.covered = 1'b1;
		o.depth = z[15:0];
		if (z[15:0] < zbuf[idx]) begin
			zbuf[idx] = z[15:0];
			o.written = 1'b1;
		end
		return o;
	endfunction

	// idle gap, so a new request never shares the step that drops valid
	task automatic idle_gap();
		int n;
		n = 1;
		if ($urandom_range(0, 2) == 0)
			n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
				: int'($urandom_range(2, 4));
		repeat (n) @(posedge clk);
	endtask

	// one request; typed result, if given, replaces the predicted one but is cross-checked
	task automatic send_frag(frag_req_t r, bit typed, frag_res_t want);
		frag_res_t p;
		p = depth_test(r);
		if (typed && (p.covered !== want.covered || p.written !== want.written ||
			p.depth !== want.depth)) begin
			$display("%0t: table row disagrees with prediction: exp %p got %p", $time, want, p);
			errors++;
		end
		expected_q = {expected_q, (typed ? want : p)};
		frag.valid <= 1'b1;
		frag.cmd <= r.cmd;
		frag.pixel_x <= r.px;
		frag.pixel_y <= r.py;
		frag.ax <= r.ax; frag.ay <= r.ay; frag.az <= r.az;
		frag.bx <= r.bx; frag.by_coord <= r.by; frag.bz <= r.bz;
		frag.cx <= r.cx; frag.cy <= r.cy; frag.cz <= r.cz;
		@(posedge clk);
		while (!frag.ready) @(posedge clk);
		frag.valid <= 1'b0;
		idle_gap();
	endtask

	task automatic write_reg(logic [0:0] idx, logic [8:0] val);
		// wait until idle, then cover the tail of a request already in flight
		while (expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == REG_SCREEN_WIDTH) width_reg = val;
		else rows_reg = val;
	endtask

	function automatic frag_req_t rand_tri(logic cmd, logic [7:0] px, logic [7:0] py);
		frag_req_t r;
		int        s;
		r.cmd = cmd;
		r.px = px;
		r.py = py;
		// mostly triangles of moderate size around the screen center, some full range
		s = ($urandom_range(0, 4) == 0) ? 32767 : int'($urandom_range(2000, 20000));
		r.ax = 16'(int'($urandom_range(0, 2 * s)) - s);
		r.ay = 16'(int'($urandom_range(0, 2 * s)) - s);
		r.bx = 16'(int'($urandom_range(0, 2 * s)) - s);
		r.by = 16'(int'($urandom_range(0, 2 * s)) - s);
		r.cx = 16'(int'($urandom_range(0, 2 * s)) - s);
		r.cy = 16'(int'($urandom_range(0, 2 * s)) - s);
		if ($urandom_range(0, 9) == 0) r.ax = 16'sh8000;
		if ($urandom_range(0, 9) == 0) r.cy = 16'sh8000;
		if ($urandom_range(0, 15) == 0) begin
			r.cx = r.ax;
			r.cy = r.ay;
		end
		r.az = 16'($urandom);
		r.bz = 16'($urandom);
		r.cz = 16'($urandom);
		if ($urandom_range(0, 1)) begin
			r.az = r.az >> 1;
			r.bz = r.bz >> 1;
			r.cz = r.cz >> 1;
		end
		return r;
	endfunction

	// result checker and sink stalls
	always @(posedge clk) begin
		frag_res_t e;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				n_results++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %b %b %h", $time, res.covered,
						res.depth_written, res.depth_value);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (res.covered !== e.covered || res.depth_written !== e.written ||
						res.depth_value !== e.depth) begin
						$display("%0t: mismatch exp cov=%b wr=%b z=%h got cov=%b wr=%b z=%h",
							$time, e.covered, e.written, e.depth, res.covered,
							res.depth_written, res.depth_value);
						errors++;
					end
					if (e.covered) n_covered++;
					if (e.written) n_written++;
				end
			end
		end
	end

	initial begin
		int n;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (done || $urandom_range(0, 3) != 0) begin
				res.ready <= 1'b1;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 200))
					: int'($urandom_range(1, 4));
				res.ready <= 1'b0;
				repeat (n) @(posedge clk);
				res.ready <= 1'b1;
			end
		end
	end

	dir_row_t dir_tab[$];

	task automatic add_row(frag_req_t r, bit typed, frag_res_t o);
		dir_row_t d;
		d.req = r;
		d.typed = typed;
		d.res = o;
		dir_tab = {dir_tab, d};
	endtask

	initial begin
		frag_req_t r;
		frag_res_t none;
		logic [7:0] cx_list[$];
		logic [7:0] cy_list[$];
		int k;
		int lim;
		errors = 0;
		n_results = 0;
		n_covered = 0;
		n_written = 0;
		n_cleared = 0;
		done = 1'b0;
		width_reg = DIM_RESET;
		rows_reg = DIM_RESET;
		none = '{1'b0, 1'b0, 16'd0};
		arst_n = 1'b0;
		frag.valid = 1'b0;
		frag.cmd = CMD_CLEAR;
		frag.pixel_x = '0; frag.pixel_y = '0;
		frag.ax = '0; frag.ay = '0; frag.az = '0;
		frag.bx = '0; frag.by_coord = '0; frag.bz = '0;
		frag.cx = '0; frag.cy = '0; frag.cz = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_SCREEN_WIDTH;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		r = '{CMD_CLEAR, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		add_row(r, 1, '{1'b0, 1'b1, DEPTH_FAR});
		r.px = 8'd255; r.py = 8'd255;
		add_row(r, 1, '{1'b0, 1'b1, DEPTH_FAR});
		r.px = 8'd64; r.py = 8'd64;
		add_row(r, 1, '{1'b0, 1'b1, DEPTH_FAR});
		// zero-area triangle
		r = '{CMD_TEST, 8'd64, 8'd64, 100, 100, 16'h1234, 200, 200, 16'h1, 300, 300, 16'h2};
		add_row(r, 1, none);
		// big triangle covering center, all vertex depths equal
		r = '{CMD_TEST, 8'd64, 8'd64, -16'sd32768, -16'sd32768, 16'h4000,
			16'sd0, 16'sd32767, 16'h4000, 16'sd32767, -16'sd32768, 16'h4000};
		add_row(r, 1, '{1'b1, 1'b1, 16'h4000});
		// same again: not nearer
		add_row(r, 1, '{1'b1, 1'b0, 16'h4000});
		// reverse winding of the same area
		r.bx = 16'sd32767; r.by = -16'sd32768; r.cx = 16'sd0; r.cy = 16'sd32767;
		add_row(r, 0, none);
		// far corner pixel, outside
		r.px = 8'd255; r.py = 8'd255;
		add_row(r, 1, none);
		// pixel at 0,0 with edges through its center, full-range depths
		r = '{CMD_TEST, 8'd0, 8'd0, 0, 0, 16'hFFFF, 0, 0, 16'h0, 0, 0, 16'h8000};
		r.ax = -16384 + 128; r.ay = -16384 + 128;
		r.bx = -16384 + 128 + 4096; r.by = -16384 + 128;
		r.cx = -16384 + 128; r.cy = -16384 + 128 + 4096;
		add_row(r, 0, none);
		r.bx = -16384 + 128 - 4096; r.cy = -16384 + 128 - 4096;
		add_row(r, 0, none);
		r.bx = -16384 + 128; r.by = -16384 + 128 + 4096;
		r.cx = -16384 + 128 + 4096; r.cy = -16384 + 128;
		add_row(r, 0, none);
		r.bz = 16'hFFFF; r.cz = 16'hFFFF;
		add_row(r, 0, none);
		for (int i = 0; i < dir_tab.size(); i++)
			send_frag(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

		// random phases over several screen sizes, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_SCREEN_WIDTH, 9'd1); write_reg(REG_SCREEN_ROWS, 9'd256); end
				1: begin write_reg(REG_SCREEN_WIDTH, 9'd256); write_reg(REG_SCREEN_ROWS, 9'd1); end
				2: begin write_reg(REG_SCREEN_WIDTH, 9'd0); write_reg(REG_SCREEN_ROWS, 9'd511); end
				3: begin write_reg(REG_SCREEN_WIDTH, 9'd300); write_reg(REG_SCREEN_ROWS, 9'd0); end
				default: begin
					write_reg(REG_SCREEN_WIDTH, 9'($urandom_range(1, 256)));
					write_reg(REG_SCREEN_ROWS, 9'($urandom_range(1, 256)));
				end
			endcase
			for (int i = 0; i < 280; i++) begin
				k = int'($urandom_range(0, 9));
				if (k < 3 || cx_list.size() == 0) begin
					lim = (i % 7 == 0) ? 255 : 15;
					r = rand_tri(CMD_CLEAR, 8'($urandom_range(0, lim)),
						8'($urandom_range(0, lim)));
					cx_list = {cx_list, r.px};
					cy_list = {cy_list, r.py};
					n_cleared++;
				end else begin
					k = int'($urandom_range(0, cx_list.size() - 1));
					r = rand_tri(CMD_TEST, cx_list[k], cy_list[k]);
				end
				send_frag(r, 0, none);
				if (i == 140) while (expected_q.size() != 0) @(posedge clk);
			end
		end

		while (expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		done = 1'b1;
		$display("covered %0d results: %0d fragments covered, %0d depth writes, %0d clears",
			n_results, n_covered, n_written, n_cleared);
		$display("six screen-size phases incl. register clamping, %0d errors", errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
